// ----- src/cdq_pkg.sv -----
// shared constants, codes and control types for the circular deque
package cdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CAP_W   = 5;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic cfg_write;
  } cdq_cmd_t;

endpackage

// ----- src/cdq_ctrl.sv -----
// controller state machine: item accept, execute and result strobe
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output cdq_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign busy      = rst || (state == ST_EXEC);
  assign cfg_ready = !rst && (state != ST_EXEC) && !start;
  assign accept    = start && !busy;
  assign done      = (state == ST_DONE);

  assign cmd.load      = accept;
  assign cmd.exec      = (state == ST_EXEC);
  assign cmd.cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- src/cdq_datapath.sv -----
// datapath: ring store, head and tail pointers, count and result registers
module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cdq_cmd_t                  cmd,
  input  logic        [OP_W-1:0]    opcode,
  input  logic signed [VALUE_W-1:0] push_value,
  input  logic        [CAP_W-1:0]   cfg_data,
  output logic        [STAT_W-1:0]  status,
  output logic signed [VALUE_W-1:0] popped_value,
  output logic        [COUNT_W-1:0] element_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW = ((IW > CAP_W) ? IW : CAP_W) + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  logic [CAP_W-1:0]   capacity;
  logic [IW-1:0]      head;
  logic [IW-1:0]      tail;
  logic               empty;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;
  logic               pop_ok;

  logic [IW-1:0]      head_next;
  logic [IW-1:0]      tail_next;
  logic               empty_next;
  logic [STAT_W-1:0]  status_next;
  logic [COUNT_W-1:0] count_next;
  logic               pop_ok_next;
  logic               we;
  logic               re;
  logic [IW-1:0]      waddr;
  logic [IW-1:0]      raddr;

  logic [AW-1:0] cap_eff;
  logic [AW-1:0] h_ext;
  logic [AW-1:0] t_ext;
  logic [AW-1:0] h_inc;
  logic [AW-1:0] h_dec;
  logic [AW-1:0] t_inc;
  logic [AW-1:0] t_dec;
  logic [AW-1:0] count_now;
  logic          full;

  always_comb begin
    if (capacity == '0) begin
      cap_eff = AW'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      cap_eff = AW'(DEPTH);
    end else begin
      cap_eff = AW'(capacity);
    end
  end

  assign h_ext = AW'(head);
  assign t_ext = AW'(tail);
  assign h_inc = (h_ext + AW'(1) >= cap_eff) ? '0 : h_ext + AW'(1);
  assign t_inc = (t_ext + AW'(1) >= cap_eff) ? '0 : t_ext + AW'(1);
  assign h_dec = (h_ext == '0) ? cap_eff - AW'(1) : h_ext - AW'(1);
  assign t_dec = (t_ext == '0) ? cap_eff - AW'(1) : t_ext - AW'(1);

  always_comb begin
    if (empty) begin
      count_now = '0;
    end else if (t_ext >= h_ext) begin
      count_now = t_ext - h_ext + AW'(1);
    end else begin
      count_now = t_ext + cap_eff - h_ext + AW'(1);
    end
  end

  assign full = (count_now >= cap_eff);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    status_next = STAT_DONE;
    count_next  = COUNT_W'(count_now);
    pop_ok_next = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = '0;
    raddr       = head;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (empty) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          we         = 1'b1;
          waddr      = '0;
          count_next = COUNT_W'(1);
        end else if (full) begin
          status_next = STAT_OVERFLOW;
        end else if (op == OP_PUSH_BACK) begin
          tail_next  = IW'(t_inc);
          we         = 1'b1;
          waddr      = IW'(t_inc);
          count_next = COUNT_W'(count_now + AW'(1));
        end else begin
          head_next  = IW'(h_dec);
          we         = 1'b1;
          waddr      = IW'(h_dec);
          count_next = COUNT_W'(count_now + AW'(1));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (empty) begin
          status_next = STAT_UNDERFLOW;
        end else begin
          re          = 1'b1;
          pop_ok_next = 1'b1;
          raddr       = (op == OP_POP_FRONT) ? head : tail;
          count_next  = COUNT_W'(count_now - AW'(1));
          if (head == tail) begin
            head_next  = '0;
            tail_next  = '0;
            empty_next = 1'b1;
          end else if (op == OP_POP_FRONT) begin
            head_next = IW'(h_inc);
          end else begin
            tail_next = IW'(t_dec);
          end
        end
      end
      default: begin
        status_next = STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= DATA_WIDTH'(value);
    end
    if (cmd.exec && re) begin
      rd_data <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= opcode;
      value <= push_value;
    end
    if (cmd.exec) begin
      status        <= status_next;
      element_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
      pop_ok   <= 1'b0;
    end else if (cmd.cfg_write) begin
      capacity <= cfg_data;
      head     <= '0;
      tail     <= '0;
      empty    <= 1'b1;
    end else if (cmd.exec) begin
      head   <= head_next;
      tail   <= tail_next;
      empty  <= empty_next;
      pop_ok <= pop_ok_next;
    end
  end

  assign popped_value = pop_ok ? VALUE_W'(rd_data) : '0;

endmodule

// ----- src/circular_deque.sv -----
// top level of the circular deque: controller plus datapath
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+------------------------------------
//   operation | start / busy              | opcode, push_value
//   result    | done (one-cycle strobe)   | status, popped_value, element_count
//   config    | cfg_valid / cfg_ready     | cfg_data (capacity)
//
// an item is accepted when start is high and busy is low; its result strobes in the DONE
// state, reached from the EXEC state, and a new item may be accepted in that same result
// cycle but not in EXEC, while busy is high and the slot memory read is registered
// synchronous reset empties the queue and sets capacity to 16; the slot memory is
// not cleared and needs no clearing pass
// the receiver cannot stall: every result is taken in its strobe cycle
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic        [OP_W-1:0]    opcode,
  input  logic signed [VALUE_W-1:0] push_value,
  output logic                      done,
  output logic        [STAT_W-1:0]  status,
  output logic signed [VALUE_W-1:0] popped_value,
  output logic        [COUNT_W-1:0] element_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [CAP_W-1:0]   cfg_data
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .opcode        (opcode),
    .push_value    (push_value),
    .cfg_data      (cfg_data),
    .status        (status),
    .popped_value  (popped_value),
    .element_count (element_count)
  );

endmodule

// ----- src/cdq_checker.sv -----
// port-level checks for the circular deque and their bind to the top level
module cdq_checker
  import cdq_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      done,
  input logic        [STAT_W-1:0]  status,
  input logic signed [VALUE_W-1:0] popped_value,
  input logic        [COUNT_W-1:0] element_count
);

  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("accepted item gave no result two cycles later");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("not busy right after an accept");

  a_no_double: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held two cycles");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status != STAT_DONE) |-> popped_value == '0)
    else $error("failed item returned a nonzero popped value");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    done && (status == STAT_UNDERFLOW) |-> element_count == '0)
    else $error("underflow with elements held");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

// ----- test/testbench.sv -----
// self-checking testbench for the circular deque: scoreboard with a deque predictor
import cdq_pkg::*;

typedef struct {
  logic [STAT_W-1:0]         status;
  logic signed [VALUE_W-1:0] popped;
  logic [COUNT_W-1:0]        count;
} deque_result_t;

class deque_scoreboard;
  logic [VALUE_W-1:0] slots [DEPTH_DEF];
  int unsigned        front_slot;
  int unsigned        back_slot;
  bit                 empty;
  logic [CAP_W-1:0]   capacity_reg;
  deque_result_t      expected_results [$];
  int                 error_count;
  int                 checked_count;

  function new();
    capacity_reg = CAP_RESET;
    error_count = 0;
    checked_count = 0;
    clear_ring();
  endfunction

  function void clear_ring();
    front_slot = 0;
    back_slot = 0;
    empty = 1'b1;
  endfunction

  function void set_capacity(logic [CAP_W-1:0] value);
    capacity_reg = value;
    clear_ring();
  endfunction

  function int unsigned slots_in_use();
    int unsigned c;
    c = 32'(capacity_reg);
    if (c == 0) c = 1;
    if (c > DEPTH_DEF) c = DEPTH_DEF;
    return c;
  endfunction

  function int unsigned held_now();
    int unsigned c;
    c = slots_in_use();
    if (empty) return 0;
    return ((back_slot + c - front_slot) % c) + 1;
  endfunction

  function int pending_count();
    return expected_results.size();
  endfunction

  // apply one accepted item to the predicted deque and queue its result
  function void note_operation(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
    deque_result_t r;
    int unsigned   c;
    c = slots_in_use();
    r.status = STAT_DONE;
    r.popped = '0;
    if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
      if (empty) begin
        front_slot = 0;
        back_slot = 0;
        empty = 1'b0;
        slots[0] = value;
      end else if (held_now() >= c) begin
        r.status = STAT_OVERFLOW;
      end else if (op == OP_PUSH_BACK) begin
        back_slot = (back_slot + 1 >= c) ? 0 : back_slot + 1;
        slots[back_slot] = value;
      end else begin
        front_slot = (front_slot == 0) ? c - 1 : front_slot - 1;
        slots[front_slot] = value;
      end
    end else begin
      if (empty) begin
        r.status = STAT_UNDERFLOW;
      end else if (op == OP_POP_FRONT) begin
        r.popped = slots[front_slot];
        if (front_slot == back_slot) clear_ring();
        else front_slot = (front_slot + 1 >= c) ? 0 : front_slot + 1;
      end else begin
        r.popped = slots[back_slot];
        if (front_slot == back_slot) clear_ring();
        else back_slot = (back_slot == 0) ? c - 1 : back_slot - 1;
      end
    end
    r.count = COUNT_W'(held_now());
    expected_results.push_back(r);
  endfunction

  task report_mismatch(string what, longint exp_v, longint got_v);
    error_count++;
    $display("mismatch at result %0d: %s expected %0d got %0d",
             checked_count, what, exp_v, got_v);
  endtask

  task check_result(logic [STAT_W-1:0] status, logic signed [VALUE_W-1:0] popped,
                    logic [COUNT_W-1:0] count);
    deque_result_t r;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no item outstanding, status", -1, longint'(status));
    end else begin
      r = expected_results.pop_front();
      if (status !== r.status)
        report_mismatch("status", longint'(r.status), longint'(status));
      if (popped !== r.popped)
        report_mismatch("popped_value", longint'(r.popped), longint'(popped));
      if (count !== r.count)
        report_mismatch("element_count", longint'(r.count), longint'(count));
    end
    checked_count++;
  endtask
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic        [OP_W-1:0]    opcode = OP_PUSH_BACK;
  logic signed [VALUE_W-1:0] push_value = '0;
  logic                      done;
  logic        [STAT_W-1:0]  status;
  logic signed [VALUE_W-1:0] popped_value;
  logic        [COUNT_W-1:0] element_count;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic        [CAP_W-1:0]   cfg_data = '0;

  deque_scoreboard sb = new();

  circular_deque u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .push_value    (push_value),
    .done          (done),
    .status        (status),
    .popped_value  (popped_value),
    .element_count (element_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, popped_value, element_count);
  end

  task send_operation(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
    start <= 1'b1;
    opcode <= op;
    push_value <= value;
    do @(posedge clk); while (busy);
    sb.note_operation(op, value);
  endtask

  task write_capacity(input logic [CAP_W-1:0] value);
    start <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_capacity(value);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 32'h8000_0000;
    if (pick == 1) return 32'h7fff_ffff;
    if (pick == 2) return 32'hffff_ffff;
    if (pick == 3) return 32'h0000_0000;
    return $urandom;
  endfunction

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0]  phase_caps [12];
    logic [OP_W-1:0]   op;
    int unsigned       idle_pct;
    int unsigned       cap_now;
    int unsigned       held;
    bit                filling;
    bit                is_push;
    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd7, 5'd2, 5'd12, 5'd5,
                   5'd15, 5'd9};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty queue, then both ends at reset capacity
    send_operation(OP_POP_FRONT, 32'h0000_0000);
    send_operation(OP_POP_BACK, 32'h7fff_ffff);
    send_operation(OP_PUSH_BACK, 32'h8000_0000);
    send_operation(OP_PUSH_FRONT, 32'h7fff_ffff);
    send_operation(OP_PUSH_BACK, 32'hffff_ffff);
    send_operation(OP_PUSH_FRONT, 32'h0000_0000);
    send_operation(OP_POP_FRONT, 32'hffff_ffff);
    send_operation(OP_POP_BACK, 32'h0000_0000);
    send_operation(OP_POP_FRONT, 32'h1234_5678);
    send_operation(OP_POP_BACK, 32'h0000_0000);
    send_operation(OP_POP_BACK, 32'h0000_0000);

    // zero capacity acts as one slot
    write_capacity(5'd0);
    send_operation(OP_PUSH_BACK, 32'h0000_0005);
    send_operation(OP_PUSH_FRONT, 32'h0000_0006);
    send_operation(OP_PUSH_BACK, 32'h0000_0007);
    send_operation(OP_POP_BACK, 32'h0000_0000);
    send_operation(OP_POP_FRONT, 32'h0000_0000);
    send_operation(OP_PUSH_BACK, 32'h0000_0008);

    // capacity write while holding an element, then front wrap
    write_capacity(5'd2);
    send_operation(OP_PUSH_FRONT, 32'h0000_0001);
    send_operation(OP_PUSH_FRONT, 32'h0000_0002);
    send_operation(OP_PUSH_BACK, 32'h0000_0003);
    send_operation(OP_POP_BACK, 32'h0000_0000);
    send_operation(OP_POP_BACK, 32'h0000_0000);

    for (int p = 0; p < 12; p++) begin
      write_capacity(phase_caps[p]);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 40;
      endcase
      if (p == 11) idle_pct = 0;
      filling = 1'b1;
      for (int k = 0; k < 120; k++) begin
        cap_now = sb.slots_in_use();
        held = sb.held_now();
        if (held >= cap_now) filling = 1'b0;
        if (held == 0) filling = 1'b1;
        if ($urandom_range(0, 49) == 0) filling = !filling;
        is_push = filling ? ($urandom_range(0, 99) < 75) : ($urandom_range(0, 99) < 25);
        if (is_push) op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        send_operation(op, pick_value());
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 19)) @(posedge clk);
        end
      end
    end

    start <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
src/cdq_pkg.sv
src/cdq_ctrl.sv
src/cdq_datapath.sv
src/circular_deque.sv
src/cdq_checker.sv
test/testbench.sv
